FILE: hdl/json_string_unescaper_assert.svh
// assertion macros shared by the rtl files
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

`ifndef ASSERT_OFF
`define JSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JSU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define JSU_ASSERT(label, prop, msg)
`define JSU_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: hdl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX0   = 3'd2,
    PH_HEX1   = 3'd3,
    PH_HEX2   = 3'd4,
    PH_HEX3   = 3'd5,
    PH_DROP   = 3'd6
  } jsu_phase_e;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_U     = 8'h75;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;

  localparam logic [15:0] CP_ONE_MAX = 16'h007F;
  localparam logic [15:0] CP_TWO_MAX = 16'h07FF;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'hE0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;

  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // result group for one request: up to three bytes, sent byte 0 first
  typedef struct packed {
    logic            valid;
    logic            error;
    logic            last;
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } jsu_grp_t;

  // {ok, digit}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {ok, mapped byte} for single-letter escapes
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      CH_QUOTE:     r = {1'b1, CH_QUOTE};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      CH_SLASH:     r = {1'b1, CH_SLASH};
      CH_LOW_B:     r = {1'b1, CH_BS};
      CH_LOW_F:     r = {1'b1, CH_FF};
      CH_LOW_N:     r = {1'b1, CH_LF};
      CH_LOW_R:     r = {1'b1, CH_CR};
      CH_LOW_T:     r = {1'b1, CH_TAB};
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/jsu_in_if.sv
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: hdl/jsu_out_if.sv
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       error;
  logic       last;

  modport source (output valid, output out_byte, output error, output last, input ready);
  modport sink (input valid, input out_byte, input error, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/jsu_step.sv
`default_nettype none

module jsu_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  logic             eos_i,
  output jsu_pkg::jsu_grp_t res_o
);
  import jsu_pkg::*;

  `include "json_string_unescaper_assert.svh"

  jsu_phase_e  phase_q, phase_d;
  logic [11:0] acc_q, acc_d;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic        esc_ok;
  logic [7:0]  esc_b;
  logic [15:0] cp;

  assign {hex_ok, hex_d} = hex_decode(byte_i);
  assign {esc_ok, esc_b} = esc_map(byte_i);
  assign cp = {acc_q, hex_d};

  // next state
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_DROP: begin
          if (eos_i) phase_d = PH_NORMAL;
        end
        PH_ESC: begin
          if (esc_ok) begin
            phase_d = PH_NORMAL;
          end else if (byte_i == CH_LOW_U && !eos_i) begin
            phase_d = PH_HEX0;
            acc_d   = '0;
          end else begin
            phase_d = (eos_i || byte_i == CH_LOW_U) ? PH_NORMAL : PH_DROP;
            acc_d   = '0;
          end
        end
        PH_HEX0, PH_HEX1, PH_HEX2: begin
          if (!hex_ok) begin
            phase_d = eos_i ? PH_NORMAL : PH_DROP;
            acc_d   = '0;
          end else if (eos_i) begin
            phase_d = PH_NORMAL;
            acc_d   = '0;
          end else begin
            phase_d = jsu_phase_e'(phase_q + 3'd1);
            acc_d   = {acc_q[7:0], hex_d};
          end
        end
        PH_HEX3: begin
          phase_d = (!hex_ok && !eos_i) ? PH_DROP : PH_NORMAL;
          acc_d   = '0;
        end
        default: begin
          phase_d = (byte_i == CH_BACKSLASH && !eos_i) ? PH_ESC : PH_NORMAL;
          if (byte_i == CH_BACKSLASH) acc_d = '0;
        end
      endcase
    end
  end

  // result group
  always_comb begin
    res_o       = '0;
    res_o.last  = eos_i;
    res_o.count = CNT_ONE;
    if (accept_i) begin
      unique case (phase_q)
        PH_DROP: begin
          res_o.valid = 1'b0;
        end
        PH_ESC: begin
          if (esc_ok) begin
            res_o.valid    = 1'b1;
            res_o.bytes[0] = esc_b;
          end else if (byte_i != CH_LOW_U || eos_i) begin
            res_o.valid = 1'b1;
            res_o.error = 1'b1;
            res_o.last  = 1'b1;
          end
        end
        PH_HEX0, PH_HEX1, PH_HEX2: begin
          if (!hex_ok || eos_i) begin
            res_o.valid = 1'b1;
            res_o.error = 1'b1;
            res_o.last  = 1'b1;
          end
        end
        PH_HEX3: begin
          res_o.valid = 1'b1;
          if (!hex_ok) begin
            res_o.error = 1'b1;
            res_o.last  = 1'b1;
          end else if (cp <= CP_ONE_MAX) begin
            res_o.bytes[0] = cp[7:0];
          end else if (cp <= CP_TWO_MAX) begin
            res_o.count    = CNT_TWO;
            res_o.bytes[0] = LEAD_TWO | {3'd0, cp[10:6]};
            res_o.bytes[1] = CONT_MARK | {2'd0, cp[5:0]};
          end else begin
            res_o.count    = CNT_THREE;
            res_o.bytes[0] = LEAD_THREE | {4'd0, cp[15:12]};
            res_o.bytes[1] = CONT_MARK | {2'd0, cp[11:6]};
            res_o.bytes[2] = CONT_MARK | {2'd0, cp[5:0]};
          end
        end
        default: begin
          if (byte_i != CH_BACKSLASH) begin
            res_o.valid    = 1'b1;
            res_o.bytes[0] = byte_i;
          end else if (eos_i) begin
            res_o.valid = 1'b1;
            res_o.error = 1'b1;
            res_o.last  = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

  `JSU_ASSERT_NEVER(drop_is_silent, accept_i && phase_q == PH_DROP && res_o.valid, "result while dropping")
  `JSU_ASSERT(end_clears_escape, accept_i && eos_i |=> phase_q == PH_NORMAL, "escape pending across strings")
  `JSU_ASSERT_NEVER(phase_in_range, phase_q > PH_DROP, "unused escape phase")

endmodule

`default_nettype wire

FILE: hdl/json_string_unescaper.sv
// json string unescaper
// in_i carries the raw bytes of an escaped json string body, one byte per
// request, with end_of_string on the final byte of each string. out_o
// carries the unescaped bytes; \u escapes come out as one to three utf-8
// bytes. a malformed escape, or a string that ends inside an escape, gives
// one request with error and last set, and the rest of that string is
// dropped. last marks the final result request of each string.
// a byte that produces output shows its first result in the cycle after
// it is taken. a new input byte is taken every cycle as long as the
// previous byte's result group is empty or is finishing in that cycle, so
// plain text flows at one byte per cycle; a \u escape that expands to more
// than one byte holds the input while the group register drains.
// when the receiver stalls the result group register holds its byte and
// the input is held off once that register is full.
// reset clears the escape state and discards any pending result.
`default_nettype none

module json_string_unescaper (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  `include "json_string_unescaper_assert.svh"

  jsu_grp_t   res;
  jsu_grp_t   grp_q, grp_d;
  logic [1:0] idx_q, idx_d;
  logic       accept;
  logic       pop;
  logic       pop_final;
  logic       idx_final;

  assign idx_final = (idx_q == grp_q.count - 2'd1);
  assign pop       = out_o.valid && out_o.ready;
  assign pop_final = pop && idx_final;
  assign in_i.ready = !grp_q.valid || pop_final;
  assign accept    = in_i.valid && in_i.ready;

  jsu_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.in_byte),
    .eos_i    (in_i.end_of_string),
    .res_o    (res)
  );

  always_comb begin
    grp_d = grp_q;
    idx_d = idx_q;
    if (accept && res.valid) begin
      grp_d = res;
      idx_d = '0;
    end else if (pop_final) begin
      grp_d.valid = 1'b0;
      idx_d       = '0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
      idx_q <= '0;
    end else begin
      grp_q <= grp_d;
      idx_q <= idx_d;
    end
  end

  assign out_o.valid = grp_q.valid;
  assign out_o.error = grp_q.error;
  assign out_o.last  = grp_q.last && idx_final;

  always_comb begin
    case (idx_q)
      2'd0:    out_o.out_byte = grp_q.bytes[0];
      2'd1:    out_o.out_byte = grp_q.bytes[1];
      default: out_o.out_byte = grp_q.bytes[2];
    endcase
  end

  `JSU_ASSERT_NEVER(grp_nonempty, grp_q.valid && grp_q.count == 2'd0, "empty result group")
  `JSU_ASSERT(err_single, grp_q.valid && grp_q.error |-> grp_q.count == CNT_ONE && grp_q.last, "error group malformed")
  `JSU_ASSERT(idx_in_range, grp_q.valid |-> idx_q < grp_q.count, "byte index beyond group")
  `JSU_ASSERT(stall_holds_idx, out_o.valid && !out_o.ready |=> $stable(idx_q) && out_o.valid, "stalled group moved")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  import jsu_pkg::*;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] STALL_PATTERN = 8'b1011_0001;
  localparam int RANDOM_BYTES = 200;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } unesc_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } raw_byte_t;

  class unescape_scoreboard;
    jsu_phase_e      phase;
    logic [15:0]     code;
    unesc_result_t   expected_q[$];
    int              errors;

    function new();
      phase  = PH_NORMAL;
      code   = '0;
      errors = 0;
    endfunction

    function void push(logic [7:0] b, logic err, logic last);
      unesc_result_t r;
      r.data = b;
      r.err  = err;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function void reject(logic eos);
      phase = eos ? PH_NORMAL : PH_DROP;
      code  = '0;
      push(8'h00, 1'b1, 1'b1);
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
      if (c >= CH_LOW_A && c <= CH_LOW_A + 8'd5) return int'(c - CH_LOW_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_A + 8'd5) return int'(c - CH_UP_A) + 10;
      return -1;
    endfunction

    function bit map_escape(logic [7:0] c, output logic [7:0] b);
      b = c;
      case (c)
        CH_QUOTE, CH_BACKSLASH, CH_SLASH: return 1'b1;
        CH_LOW_B: b = CH_BS;
        CH_LOW_F: b = CH_FF;
        CH_LOW_N: b = CH_LF;
        CH_LOW_R: b = CH_CR;
        CH_LOW_T: b = CH_TAB;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void encode_point(logic [15:0] cp, logic last);
      if (cp <= CP_ONE_MAX) begin
        push(cp[7:0], 1'b0, last);
      end else if (cp <= CP_TWO_MAX) begin
        push(LEAD_TWO | {3'b000, cp[10:6]}, 1'b0, 1'b0);
        push(CONT_MARK | {2'b00, cp[5:0]}, 1'b0, last);
      end else begin
        push(LEAD_THREE | {4'b0000, cp[15:12]}, 1'b0, 1'b0);
        push(CONT_MARK | {2'b00, cp[11:6]}, 1'b0, 1'b0);
        push(CONT_MARK | {2'b00, cp[5:0]}, 1'b0, last);
      end
    endfunction

    function void note_request(logic [7:0] c, logic eos);
      logic [7:0] mapped;
      int d;
      case (phase)
        PH_DROP: begin
          if (eos) phase = PH_NORMAL;
        end
        PH_ESC: begin
          if (c == CH_LOW_U) begin
            if (eos) begin
              reject(1'b1);
            end else begin
              phase = PH_HEX0;
              code  = '0;
            end
          end else if (map_escape(c, mapped)) begin
            phase = PH_NORMAL;
            push(mapped, 1'b0, eos);
          end else begin
            reject(eos);
          end
        end
        PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
          d = hex_value(c);
          if (d < 0) begin
            reject(eos);
          end else begin
            code = {code[11:0], d[3:0]};
            if (phase == PH_HEX3) begin
              phase = PH_NORMAL;
              encode_point(code, eos);
            end else if (eos) begin
              reject(1'b1);
            end else begin
              phase = jsu_phase_e'(phase + 3'd1);
            end
          end
        end
        default: begin
          phase = PH_NORMAL;
          if (c == CH_BACKSLASH) begin
            if (eos) reject(1'b1);
            else phase = PH_ESC;
          end else begin
            push(c, 1'b0, eos);
          end
        end
      endcase
    endfunction

    function void check_result(logic [7:0] b, logic err, logic last);
      unesc_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: byte %h error %b last %b", $time, b, err, last);
        return;
      end
      e = expected_q.pop_front();
      if (err !== e.err) begin
        errors++;
        $display("%0t error flag: expected %b actual %b", $time, e.err, err);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t last flag: expected %b actual %b", $time, e.last, last);
      end
      if (!e.err && b !== e.data) begin
        errors++;
        $display("%0t out_byte: expected %h actual %h", $time, e.data, b);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jsu_in_if  in_bus ();
  jsu_out_if out_bus ();

  json_string_unescaper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  unescape_scoreboard sb;
  raw_byte_t  stim_q[$];
  logic [7:0] str_q[$];
  int         burst_left;
  logic [7:0] rcv_cycle;

  always #5 clk_i = ~clk_i;

  initial begin
    sb = new();
    in_bus.valid         = 1'b0;
    in_bus.in_byte       = 8'h00;
    in_bus.end_of_string = 1'b0;
    out_bus.ready        = 1'b0;
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rcv_cycle     <= '0;
    end else begin
      rcv_cycle <= rcv_cycle + 8'd1;
      case (rcv_cycle[7:6])
        2'd0: out_bus.ready <= 1'b1;
        2'd1: out_bus.ready <= 1'($urandom_range(0, 1));
        2'd2: out_bus.ready <= STALL_PATTERN[rcv_cycle[2:0]];
        default: out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.out_byte, out_bus.error, out_bus.last);
      if (in_bus.valid && in_bus.ready)
        sb.note_request(in_bus.in_byte, in_bus.end_of_string);
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 4'd10) return CH_ZERO + {4'h0, nib};
    return (upper ? CH_UP_A : CH_LOW_A) + {4'h0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] bad_letter();
    logic [7:0] c;
    logic [7:0] dummy;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_LOW_U || sb.map_escape(c, dummy));
    return c;
  endfunction

  function automatic logic [7:0] bad_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (sb.hex_value(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic logic [7:0] good_letter();
    logic [7:0] letters[8];
    letters = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOW_B,
                CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};
    return letters[$urandom_range(0, 7)];
  endfunction

  task automatic put_escape(logic [7:0] letter);
    str_q.push_back(CH_BACKSLASH);
    str_q.push_back(letter);
  endtask

  task automatic put_unicode(logic [15:0] cp, logic [3:0] upper);
    str_q.push_back(CH_BACKSLASH);
    str_q.push_back(CH_LOW_U);
    for (int i = 3; i >= 0; i--)
      str_q.push_back(hex_char(cp[i*4 +: 4], upper[i]));
  endtask

  task automatic end_string();
    raw_byte_t item;
    foreach (str_q[i]) begin
      item.data = str_q[i];
      item.eos  = (i == str_q.size() - 1);
      stim_q.push_back(item);
    end
    str_q.delete();
  endtask

  task automatic random_string();
    int tokens;
    int r;
    int k;
    logic [15:0] cp;
    tokens = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) begin
      // noise
      repeat (tokens) str_q.push_back(8'($urandom_range(0, 255)));
      end_string();
      return;
    end
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        str_q.push_back(plain_byte());
      end else if (r < 65) begin
        put_escape(good_letter());
      end else if (r < 87) begin
        case ($urandom_range(0, 3))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          default: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
        endcase
        put_unicode(cp, 4'($urandom_range(0, 15)));
      end else if (r < 91) begin
        put_escape(bad_letter());
      end else if (r < 95) begin
        str_q.push_back(CH_BACKSLASH);
        str_q.push_back(CH_LOW_U);
        k = $urandom_range(0, 3);
        repeat (k) str_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
        str_q.push_back(bad_hex());
      end else begin
        // string cut short inside an escape
        str_q.push_back(CH_BACKSLASH);
        k = $urandom_range(0, 4);
        if (k > 0) str_q.push_back(CH_LOW_U);
        for (int i = 1; i < k; i++)
          str_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom)));
        end_string();
        return;
      end
    end
    end_string();
  endtask

  task automatic drive_stream();
    raw_byte_t item;
    int gap;
    while (stim_q.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      item = stim_q.pop_front();
      in_bus.valid         <= 1'b1;
      in_bus.in_byte       <= item.data;
      in_bus.end_of_string <= item.eos;
      do @(posedge clk_i); while (!in_bus.ready);
      burst_left--;
    end
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    // let the last accepted request be noted before the pending count is checked
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain bytes: nul and extremes
    str_q.push_back(8'h00);
    str_q.push_back(8'hFF);
    str_q.push_back(8'h41);
    end_string();
    // all single-letter escapes, the last one ending the string
    put_escape(CH_QUOTE);
    put_escape(CH_BACKSLASH);
    put_escape(CH_SLASH);
    put_escape(CH_LOW_B);
    put_escape(CH_LOW_F);
    put_escape(CH_LOW_N);
    put_escape(CH_LOW_R);
    put_escape(CH_LOW_T);
    end_string();
    // utf-8 length boundaries, mixed case, surrogate on its own
    put_unicode(16'h007F, 4'b0000);
    put_unicode(16'h07FF, 4'b0101);
    put_unicode(16'hFFFF, 4'b1111);
    put_unicode(16'hD83D, 4'b0010);
    end_string();
    // bad letter mid string, then at end of string
    put_escape(bad_letter());
    str_q.push_back(CH_LOW_X);
    end_string();
    put_escape(bad_letter());
    end_string();
    // bad hex digit mid string
    str_q.push_back(CH_BACKSLASH);
    str_q.push_back(CH_LOW_U);
    str_q.push_back(CH_ZERO);
    str_q.push_back(bad_hex());
    str_q.push_back(CH_LOW_X);
    end_string();
    // strings ending inside an escape
    str_q.push_back(CH_LOW_A);
    str_q.push_back(CH_BACKSLASH);
    end_string();
    str_q.push_back(CH_BACKSLASH);
    str_q.push_back(CH_LOW_U);
    end_string();
    str_q.push_back(CH_BACKSLASH);
    str_q.push_back(CH_LOW_U);
    str_q.push_back(CH_ZERO + 8'd1);
    str_q.push_back(CH_ZERO + 8'd2);
    end_string();
    drive_stream();

    // hold off until the directed part has fully drained
    wait_drained();

    while (stim_q.size() < RANDOM_BYTES) random_string();
    drive_stream();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
